/* sv/min_max_normalizer_core_macros.svh */
// assertion macros shared by the normaliser modules
`ifndef MIN_MAX_NORMALIZER_CORE_MACROS_SVH
`define MIN_MAX_NORMALIZER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MMN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mmn_pkg.sv */
// shared command and status types for the normaliser controller and datapath
package mmn_pkg;

	// commands from the controller to the datapath
	typedef struct packed {
		logic track;     // fold the incoming sample into min and max
		logic clear;     // return min and max to their reset values
		logic load_num;  // take the read sample, start a new division
		logic step;      // one divider iteration
	} mmn_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_done;  // the current step is the last of the division
	} mmn_sts_t;

endpackage

/* sv/min_max_normalizer_core.sv */
// top level of the min-max normaliser: controller, datapath and sample store
//
//  channel  | direction | tdata               | tuser      | tlast
//  s_*      | in        | sample (signed)     | -          | final_sample
//  m_*      | out       | scaled (unsigned)   | degenerate | end_of_set
//
// samples load at one transfer per cycle while s_tready is high
// each result is made by these steps in turn, the output waiting for m_tready:
//   one store read, one operand load, FRACTION_BITS + 1 divider iterations, one output
// the single restoring divider in the datapath sets the result rate
// reset clears the fill count, min and max; the store itself is not cleared
// s_tready is low from the final sample until the last result has been transferred
module min_max_normalizer_core
	import mmn_pkg::*;
#(
	parameter int MAX_SAMPLES   = 64,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
	input  logic                                  s_tlast,   // final_sample
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((FRACTION_BITS+8)/8)*8-1:0]    m_tdata,   // scaled
	output logic                                  m_tuser,   // degenerate
	output logic                                  m_tlast    // end_of_set
);

	localparam int AW     = $clog2(MAX_SAMPLES);
	localparam int OUT_W  = ((FRACTION_BITS + 8) / 8) * 8;

	mmn_cmd_t                 cmd;
	mmn_sts_t                 sts;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [SAMPLE_BITS-1:0]   rd_sample;
	logic [FRACTION_BITS:0]   scaled;

	// sequencing
	mmn_ctrl #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tlast   (m_tlast),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.cmd       (cmd),
		.sts       (sts)
	);

	// sample store
	mmn_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata[SAMPLE_BITS-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_sample)
	);

	// arithmetic
	mmn_dp #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sample     (s_tdata[SAMPLE_BITS-1:0]),
		.rd_sample  (rd_sample),
		.scaled     (scaled),
		.degenerate (m_tuser)
	);

	// result payload, zero padded to whole bytes
	assign m_tdata = OUT_W'(scaled);

endmodule

/* sv/mmn_ram.sv */
// generic single-write, single-read ram with registered read data
module mmn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/mmn_ctrl.sv */
// controller: load phase, per-sample read, divide and output sequencing
module mmn_ctrl
	import mmn_pkg::*;
#(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic                           m_tlast,
	output logic                           ram_we,
	output logic [$clog2(MAX_SAMPLES)-1:0] ram_waddr,
	output logic                           ram_re,
	output logic [$clog2(MAX_SAMPLES)-1:0] ram_raddr,
	output mmn_cmd_t                       cmd,
	input  mmn_sts_t                       sts
);

	`include "min_max_normalizer_core_macros.svh"

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          in_xfer;
	logic          out_xfer;
	logic          room;

	// handshake and command decode
	always_comb begin
		s_tready      = (state_q == ST_LOAD);
		m_tvalid      = (state_q == ST_OUT);
		m_tlast       = m_tvalid && (CW'(idx_q + 1'b1) == cnt_q);
		in_xfer       = s_tvalid && s_tready;
		out_xfer      = m_tvalid && m_tready;
		room          = (cnt_q < CW'(MAX_SAMPLES));
		ram_we        = in_xfer && room;
		ram_waddr     = cnt_q[AW-1:0];
		ram_re        = (state_q == ST_READ);
		ram_raddr     = idx_q[AW-1:0];
		cmd.track     = in_xfer && room;
		cmd.clear     = out_xfer && m_tlast;
		cmd.load_num  = (state_q == ST_FETCH);
		cmd.step      = (state_q == ST_DIV);
	end

	// state, fill count and output index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (room) begin
							cnt_q <= CW'(cnt_q + 1'b1);
						end
						if (s_tlast) begin
							idx_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_xfer) begin
						if (m_tlast) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= CW'(idx_q + 1'b1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// checks
	`MMN_ASSERT_NOW(a_out_in_range, clk, arst_n, m_tvalid, (idx_q < cnt_q), "output index past fill count")
	`MMN_ASSERT_NEXT(a_set_clears, clk, arst_n, (out_xfer && m_tlast), (cnt_q == '0 && s_tready), "set not cleared after last result")
	`MMN_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, (cnt_q <= CW'(MAX_SAMPLES)), "fill count beyond store depth")

endmodule

/* sv/mmn_dp.sv */
// datapath: running min and max, span, and a shared restoring divider
module mmn_dp
	import mmn_pkg::*;
#(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mmn_cmd_t                 cmd,
	output mmn_sts_t                 sts,
	input  logic [SAMPLE_BITS-1:0]   sample,
	input  logic [SAMPLE_BITS-1:0]   rd_sample,
	output logic [FRACTION_BITS:0]   scaled,
	output logic                     degenerate
);

	`include "min_max_normalizer_core_macros.svh"

	localparam int SB = SAMPLE_BITS;
	localparam int FB = FRACTION_BITS;
	localparam int STW = $clog2(FB + 1);
	localparam logic signed [SB-1:0] MOST_POS = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};

	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic [SB:0]          rem_q;
	logic [FB:0]          quot_q;
	logic [STW-1:0]       step_q;
	logic [SB-1:0]        span;
	logic [SB-1:0]        num;
	logic [SB:0]          trial;
	logic                 fits;

	// span and numerator of the current sample
	always_comb begin
		span       = SB'(max_q - min_q);
		num        = SB'($signed(rd_sample) - min_q);
		degenerate = (span == '0);
		scaled     = degenerate ? '0 : quot_q;
	end

	// one divider iteration: the first compares unshifted, the rest shift first
	always_comb begin
		trial        = (step_q == '0) ? rem_q : {rem_q[SB-1:0], 1'b0};
		fits         = (trial >= {1'b0, span});
		sts.div_done = cmd.step && (step_q == STW'(FB));
	end

	// running minimum and maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MOST_POS;
			max_q <= MOST_NEG;
		end else if (cmd.clear) begin
			min_q <= MOST_POS;
			max_q <= MOST_NEG;
		end else if (cmd.track) begin
			if ($signed(sample) < min_q) begin
				min_q <= $signed(sample);
			end
			if ($signed(sample) > max_q) begin
				max_q <= $signed(sample);
			end
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load_num) begin
			step_q <= '0;
		end else if (cmd.step) begin
			step_q <= STW'(step_q + 1'b1);
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (cmd.load_num) begin
			rem_q  <= {1'b0, num};
			quot_q <= '0;
		end else if (cmd.step) begin
			rem_q  <= fits ? (trial - {1'b0, span}) : trial;
			quot_q <= {quot_q[FB-1:0], fits};
		end
	end

	// checks
	`MMN_ASSERT_NOW(a_order, clk, arst_n, cmd.load_num, (max_q >= min_q), "min above max when reading out")
	`MMN_ASSERT_NEXT(a_rem_bound, clk, arst_n, (cmd.step && !degenerate), (rem_q < {1'b0, span}), "remainder not below span")
	`MMN_ASSERT_NEXT(a_quot_bound, clk, arst_n, (sts.div_done && !degenerate), (quot_q <= ((FB+1)'(1) << FB)), "quotient above one")

endmodule
